FILE: rtl/trd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trd_pkg
// Shared types and constants for the run-length pixel decoder.
// ----------------------------------------------------------------------------
package trd_pkg;

  // header byte fields
  localparam logic [7:0]  COUNT_MASK = 8'h7f;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PIXEL_W    = 32;
  localparam int unsigned RUN_W      = 8;
  localparam int unsigned FRAME_W    = 25;

  // frame size limit, and the reset values of the registers
  localparam logic [FRAME_W-1:0] MAX_FRAME   = 25'h1000000;
  localparam logic [2:0]         BPP_RESET   = 3'd1;
  localparam logic [FRAME_W-1:0] TOTAL_RESET = 25'd1;

  // register map, by word index
  typedef enum logic {
    REG_BPP   = 1'b0,
    REG_TOTAL = 1'b1
  } reg_idx_t;

  // effective configuration seen by the decoder
  typedef struct packed {
    logic [1:0]         bpp_m1;  // pixel size less one
    logic [FRAME_W-1:0] total;   // pixels per frame, 1 .. 2^24
  } cfg_t;

  // one decoded result
  typedef struct packed {
    logic               emit;
    logic [PIXEL_W-1:0] pixel_value;
    logic [RUN_W-1:0]   run_length;
    logic               frame_end;
    logic               overrun;
  } result_t;

endpackage

FILE: rtl/trd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trd_cfg_regs
// Configuration registers behind the bus port, with the clamped values
// that the decoder works from.
// ----------------------------------------------------------------------------
module trd_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output trd_pkg::cfg_t cfg
);
  import trd_pkg::*;

  logic [2:0]         pixel_size;
  logic [FRAME_W-1:0] total_pixels;
  logic               wr_en;
  reg_idx_t           idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel & penable & pwrite & pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_size   <= BPP_RESET;
      total_pixels <= TOTAL_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_BPP:   pixel_size   <= pwdata[2:0];
        REG_TOTAL: total_pixels <= pwdata[FRAME_W-1:0];
        default:   ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      REG_BPP:   prdata = {29'd0, pixel_size};
      REG_TOTAL: prdata = {7'd0, total_pixels};
      default:   prdata = 32'd0;
    endcase
  end

  // clamp pixel size to 1..4, stored less one
  always_comb begin
    case (pixel_size) inside
      3'd0, 3'd1: cfg.bpp_m1 = 2'd0;
      3'd2:       cfg.bpp_m1 = 2'd1;
      3'd3:       cfg.bpp_m1 = 2'd2;
      default:    cfg.bpp_m1 = 2'd3;
    endcase
  end

  // clamp frame size to 1..2^24
  always_comb begin
    if (total_pixels == '0) begin
      cfg.total = TOTAL_RESET;
    end else if (total_pixels > MAX_FRAME) begin
      cfg.total = MAX_FRAME;
    end else begin
      cfg.total = total_pixels;
    end
  end

endmodule

FILE: rtl/trd_decode_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trd_decode_core
// Packet and pixel state of the decoder; takes one byte per advance and
// produces at most one result.
// ----------------------------------------------------------------------------
module trd_decode_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [7:0]       data_byte,
  input  trd_pkg::cfg_t    cfg,
  output trd_pkg::result_t result
);
  import trd_pkg::*;

  // decoder state
  logic [RUN_W-1:0]   packet_left, packet_left_next;
  logic               repeat_mode, repeat_mode_next;
  logic [1:0]         byte_position, byte_position_next;
  logic [PIXEL_W-1:0] pixel_gather, pixel_gather_next;
  logic [FRAME_W-1:0] pixels_decoded, pixels_decoded_next;
  logic               clipped, clipped_next;

  // header path
  logic [RUN_W-1:0]   count;
  logic [FRAME_W-1:0] remaining;
  logic               over;

  // pixel path
  logic [PIXEL_W-1:0] gathered;
  logic               pixel_done;
  logic [RUN_W-1:0]   run;
  logic [RUN_W-1:0]   left_after;
  logic [FRAME_W:0]   sum;
  logic               fend;

  // packet header: count and pixels left in the frame
  always_comb begin
    count     = {1'b0, data_byte[6:0] & COUNT_MASK[6:0]} + 8'd1;
    remaining = (pixels_decoded < cfg.total) ? (cfg.total - pixels_decoded)
                                             : TOTAL_RESET;
    over      = {{(FRAME_W-RUN_W){1'b0}}, count} > remaining;
  end

  // pixel byte: gather and finish a pixel
  always_comb begin
    gathered   = pixel_gather |
                 ({{(PIXEL_W-BYTE_W){1'b0}}, data_byte} << {byte_position, 3'b000});
    pixel_done = byte_position >= cfg.bpp_m1;
    run        = repeat_mode ? packet_left : 8'd1;
    left_after = repeat_mode ? '0 : packet_left - 8'd1;
    sum        = {1'b0, pixels_decoded} + {{(FRAME_W+1-RUN_W){1'b0}}, run};
    fend       = sum >= {1'b0, cfg.total};
  end

  // next state and result
  always_comb begin
    packet_left_next    = packet_left;
    repeat_mode_next    = repeat_mode;
    byte_position_next  = byte_position;
    pixel_gather_next   = pixel_gather;
    pixels_decoded_next = pixels_decoded;
    clipped_next        = clipped;
    result.emit         = 1'b0;
    result.pixel_value  = gathered;
    result.run_length   = run;
    result.frame_end    = fend;
    result.overrun      = clipped & (left_after == '0);
    if (packet_left == '0) begin
      packet_left_next   = over ? remaining[RUN_W-1:0] : count;
      clipped_next       = over;
      repeat_mode_next   = data_byte[7];
      byte_position_next = 2'd0;
      pixel_gather_next  = '0;
    end else if (pixel_done) begin
      result.emit         = 1'b1;
      packet_left_next    = left_after;
      pixels_decoded_next = fend ? '0 : sum[FRAME_W-1:0];
      if (left_after == '0) begin
        clipped_next = 1'b0;
      end
      byte_position_next = 2'd0;
      pixel_gather_next  = '0;
    end else begin
      byte_position_next = byte_position + 2'd1;
      pixel_gather_next  = gathered;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      packet_left    <= '0;
      repeat_mode    <= 1'b0;
      byte_position  <= 2'd0;
      pixel_gather   <= '0;
      pixels_decoded <= '0;
      clipped        <= 1'b0;
    end else if (advance) begin
      packet_left    <= packet_left_next;
      repeat_mode    <= repeat_mode_next;
      byte_position  <= byte_position_next;
      pixel_gather   <= pixel_gather_next;
      pixels_decoded <= pixels_decoded_next;
      clipped        <= clipped_next;
    end
  end

endmodule

FILE: rtl/tga_rle_pixel_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// Run-length image stream decoder: header and pixel bytes in, pixels with
// run lengths out.
// ----------------------------------------------------------------------------
// The block takes one stream byte per clock and sustains that rate while the
// pixel side keeps up. A byte is held in an input register and decoded there
// against the packet state, and a finished pixel lands in the output
// register, from which the result is presented. Header bytes and bytes
// inside a pixel give no result. The input register and the output register
// part the two sides: a new byte is taken while a result waits, and the byte
// side stalls only when the waiting result is itself stalled. A repeat
// packet yields one result carrying its whole run length. Program the pixel
// size in bytes (address 0) and total_pixels (address 4) while the stream is
// idle.
module tga_rle_pixel_decoder (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // byte stream
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  // decoded pixels
  output logic        pixel_valid,
  input  logic        pixel_stall,
  output logic [31:0] pixel_value,
  output logic [7:0]  run_length,
  output logic        frame_end,
  output logic        overrun
);
  import trd_pkg::*;

  cfg_t       cfg;
  result_t    result;
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       advance;

  trd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // decode a held byte when the output slot is free or being emptied
  assign advance    = hold_valid & (~pixel_valid | ~pixel_stall);
  assign byte_stall = hold_valid & ~advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!byte_stall) begin
      hold_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      hold_byte <= data_byte;
    end
  end

  trd_decode_core u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .data_byte (hold_byte),
    .cfg       (cfg),
    .result    (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (advance && result.emit) begin
      pixel_valid <= 1'b1;
    end else if (!pixel_stall) begin
      pixel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      pixel_value <= result.pixel_value;
      run_length  <= result.run_length;
      frame_end   <= result.frame_end;
      overrun     <= result.overrun;
    end
  end

endmodule
